// ===== rtl/core/bpcw_pkg.sv =====
// ----------------------------------------------------------------------------
// bpcw_pkg
// Shared widths, codes and control types of the BSP point contents walk.
// ----------------------------------------------------------------------------
package bpcw_pkg;

  localparam int unsigned NODE_COUNT_DEF = 4096;
  localparam int unsigned MAX_STEPS_DEF  = 64;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned CHILD_W     = 13;
  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned NORM_W      = 18;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned CONT_W      = 5;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned PROD_W      = NORM_W + COORD_W;
  localparam int unsigned AXIAL_TYPES = 3;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam int unsigned PLANE_W = TYPE_W + 3 * NORM_W;
  localparam int unsigned LINK_W  = COORD_W + 2 * CHILD_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  localparam logic [IDX_W-1:0] FIRST_RESET = '0;
  localparam logic [IDX_W-1:0] LAST_RESET  = '1;

  localparam logic signed [CHILD_W-1:0] LEAF_MIN = CHILD_W'(-16);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_LEAF,
    RES_BAD,
    RES_DEEP
  } result_kind_t;

  typedef struct packed {
    logic         mem_write;
    logic         load_query;
    logic         mem_read;
    logic         mul_en;
    axis_t        mul_sel;
    acc_op_t      acc_op;
    logic         step_axial;
    logic         step_general;
    logic         load_result;
    result_kind_t kind;
  } bpcw_cmd_t;

  typedef struct packed {
    logic is_leaf;
    logic out_of_range;
    logic step_limit;
    logic axial;
  } bpcw_stat_t;

endpackage

// ===== rtl/core/bpcw_req_if.sv =====
// ----------------------------------------------------------------------------
// bpcw_req_if
// Input item channel: node writes and point queries.
// ----------------------------------------------------------------------------
interface bpcw_req_if;
  import bpcw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IDX_W-1:0]          node_index;
  logic [TYPE_W-1:0]         plane_type;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;
  logic signed [NORM_W-1:0]  normal_z;
  logic signed [COORD_W-1:0] plane_distance;
  logic signed [CHILD_W-1:0] front_child;
  logic signed [CHILD_W-1:0] back_child;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (
    output valid, opcode, node_index, plane_type, normal_x, normal_y, normal_z,
           plane_distance, front_child, back_child, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, node_index, plane_type, normal_x, normal_y, normal_z,
           plane_distance, front_child, back_child, point_x, point_y, point_z,
    output ready
  );
endinterface

// ===== rtl/core/bpcw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bpcw_rsp_if
// Result item channel: leaf contents and error flags.
// ----------------------------------------------------------------------------
interface bpcw_rsp_if;
  import bpcw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CONT_W-1:0] contents;
  logic                     bad_node;
  logic                     too_deep;

  modport source (
    output valid, contents, bad_node, too_deep,
    input  ready
  );

  modport sink (
    input  valid, contents, bad_node, too_deep,
    output ready
  );
endinterface

// ===== rtl/core/bpcw_dp.sv =====
// ----------------------------------------------------------------------------
// bpcw_dp
// Walk datapath: node memories, point registers, shared multiplier,
// distance accumulator, child selection and the result register.
// ----------------------------------------------------------------------------
module bpcw_dp #(
  parameter int unsigned NODE_COUNT = bpcw_pkg::NODE_COUNT_DEF,
  parameter int unsigned MAX_STEPS  = bpcw_pkg::MAX_STEPS_DEF
) (
  input  logic                                        clk,
  input  bpcw_pkg::bpcw_cmd_t                         cmd,
  output bpcw_pkg::bpcw_stat_t                        stat,
  input  logic [bpcw_pkg::IDX_W-1:0]                  first_valid_node,
  input  logic [bpcw_pkg::IDX_W-1:0]                  last_valid_node,
  input  logic [bpcw_pkg::IDX_W-1:0]                  node_index,
  input  logic [bpcw_pkg::TYPE_W-1:0]                 plane_type,
  input  logic signed [bpcw_pkg::NORM_W-1:0]          normal_x,
  input  logic signed [bpcw_pkg::NORM_W-1:0]          normal_y,
  input  logic signed [bpcw_pkg::NORM_W-1:0]          normal_z,
  input  logic signed [bpcw_pkg::COORD_W-1:0]         plane_distance,
  input  logic signed [bpcw_pkg::CHILD_W-1:0]         front_child,
  input  logic signed [bpcw_pkg::CHILD_W-1:0]         back_child,
  input  logic signed [bpcw_pkg::COORD_W-1:0]         point_x,
  input  logic signed [bpcw_pkg::COORD_W-1:0]         point_y,
  input  logic signed [bpcw_pkg::COORD_W-1:0]         point_z,
  output logic signed [bpcw_pkg::CONT_W-1:0]          contents,
  output logic                                        bad_node,
  output logic                                        too_deep
);
  import bpcw_pkg::*;

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned SW = $clog2(MAX_STEPS + 1);

  logic [PLANE_W-1:0] plane_mem [NODE_COUNT];
  logic [LINK_W-1:0]  link_mem  [NODE_COUNT];

  logic [PLANE_W-1:0]         plane_q;
  logic [LINK_W-1:0]          link_q;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;
  logic signed [COORD_W-1:0]  pz;
  logic signed [CHILD_W-1:0]  num;
  logic [SW-1:0]              steps;
  logic signed [PROD_W-1:0]   prod;
  logic [COORD_W-1:0]         acc;

  logic [TYPE_W-1:0]          q_type;
  logic signed [NORM_W-1:0]   q_nx;
  logic signed [NORM_W-1:0]   q_ny;
  logic signed [NORM_W-1:0]   q_nz;
  logic [COORD_W-1:0]         q_dist;
  logic signed [CHILD_W-1:0]  q_front;
  logic signed [CHILD_W-1:0]  q_back;

  logic                       wr_in_table;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [31:0]                num_w;
  logic signed [NORM_W-1:0]   mul_a;
  logic signed [COORD_W-1:0]  mul_b;
  logic [COORD_W-1:0]         prod_sh;
  logic signed [COORD_W-1:0]  pt_sel;
  logic [COORD_W-1:0]         d_axial;
  logic [COORD_W-1:0]         d_general;

  assign q_type  = plane_q[TYPE_W-1:0];
  assign q_nx    = plane_q[TYPE_W +: NORM_W];
  assign q_ny    = plane_q[TYPE_W + NORM_W +: NORM_W];
  assign q_nz    = plane_q[TYPE_W + 2 * NORM_W +: NORM_W];
  assign q_dist  = link_q[COORD_W-1:0];
  assign q_front = link_q[COORD_W +: CHILD_W];
  assign q_back  = link_q[COORD_W + CHILD_W +: CHILD_W];

  assign wr_in_table = (32'(node_index) < 32'(NODE_COUNT));
  assign wr_addr     = AW'(node_index);
  assign rd_addr     = AW'(num[IDX_W-1:0]);
  assign num_w       = 32'(num[IDX_W-1:0]);

  assign stat.is_leaf      = num[CHILD_W-1];
  assign stat.out_of_range = (num_w < 32'(first_valid_node)) ||
                             (num_w > 32'(last_valid_node)) ||
                             (num_w >= 32'(NODE_COUNT));
  assign stat.step_limit   = (steps >= SW'(MAX_STEPS));
  assign stat.axial        = (q_type < TYPE_W'(AXIAL_TYPES));

  always_comb begin
    case (cmd.mul_sel)
      AXIS_X: begin
        mul_a = q_nx;
        mul_b = px;
      end
      AXIS_Y: begin
        mul_a = q_ny;
        mul_b = py;
      end
      default: begin
        mul_a = q_nz;
        mul_b = pz;
      end
    endcase
  end

  always_comb begin
    case (q_type)
      TYPE_W'(0): pt_sel = px;
      TYPE_W'(1): pt_sel = py;
      default:    pt_sel = pz;
    endcase
  end

  assign prod_sh   = prod[FRAC_W +: COORD_W];
  assign d_axial   = pt_sel - q_dist;
  assign d_general = acc + prod_sh - q_dist;

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_in_table) begin
      plane_mem[wr_addr] <= {normal_z, normal_y, normal_x, plane_type};
      link_mem[wr_addr]  <= {back_child, front_child, plane_distance};
    end
    if (cmd.mem_read) begin
      plane_q <= plane_mem[rd_addr];
      link_q  <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px    <= point_x;
      py    <= point_y;
      pz    <= point_z;
      num   <= signed'({1'b0, node_index});
      steps <= '0;
    end
    if (cmd.mem_read) begin
      steps <= steps + SW'(1);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod_sh;
      ACC_ADD:  acc <= acc + prod_sh;
      default:  acc <= acc;
    endcase
    if (cmd.step_axial) begin
      num <= d_axial[COORD_W-1] ? q_back : q_front;
    end
    if (cmd.step_general) begin
      num <= d_general[COORD_W-1] ? q_back : q_front;
    end
    if (cmd.load_result) begin
      case (cmd.kind)
        RES_LEAF: begin
          contents <= (num < LEAF_MIN) ? LEAF_MIN[CONT_W-1:0] : num[CONT_W-1:0];
          bad_node <= 1'b0;
          too_deep <= 1'b0;
        end
        RES_BAD: begin
          contents <= '0;
          bad_node <= 1'b1;
          too_deep <= 1'b0;
        end
        RES_DEEP: begin
          contents <= '0;
          bad_node <= 1'b0;
          too_deep <= 1'b1;
        end
        default: begin
          contents <= '0;
          bad_node <= 1'b0;
          too_deep <= 1'b0;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/bpcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpcw_ctrl
// Walk sequencer: accepts items, steps the datapath through each tree level
// and holds the result valid flag.
// ----------------------------------------------------------------------------
module bpcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_opcode,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  bpcw_pkg::bpcw_stat_t  stat,
  output bpcw_pkg::bpcw_cmd_t   cmd
);
  import bpcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FINISH
  } state_t;

  state_t       state;
  state_t       state_next;
  result_kind_t kind;
  result_kind_t kind_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_opcode == OP_QUERY) begin
            cmd.load_query = 1'b1;
            state_next     = S_CHECK;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (stat.is_leaf) begin
          kind_next  = RES_LEAF;
          state_next = S_FINISH;
        end else if (stat.out_of_range) begin
          kind_next  = RES_BAD;
          state_next = S_FINISH;
        end else if (stat.step_limit) begin
          kind_next  = RES_DEEP;
          state_next = S_FINISH;
        end else begin
          cmd.mem_read = 1'b1;
          state_next   = S_MUL0;
        end
      end
      S_MUL0: begin
        if (stat.axial) begin
          cmd.step_axial = 1'b1;
          state_next     = S_CHECK;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = AXIS_X;
          state_next  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = AXIS_Y;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = AXIS_Z;
        cmd.acc_op  = ACC_ADD;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.step_general = 1'b1;
        state_next       = S_CHECK;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_result = 1'b1;
          cmd.kind        = kind;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= RES_LEAF;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/core/bsp_point_contents_walk.sv =====
// ----------------------------------------------------------------------------
// bsp_point_contents_walk
// Classifies a fixed-point point against a table of BSP clip nodes and
// returns the contents of the leaf that it reaches.
//
//   channel | dir | handshake       | items
//   --------+-----+-----------------+-------------------------------------
//   req     | in  | valid/ready     | node write or point query
//   rsp     | out | valid/ready     | contents, bad_node, too_deep
//   cfg     | in  | APB psel/penable| first_valid_node, last_valid_node
//
// A node write is taken in the idle state. On each tree level a query
// checks and reads the node; a general plane shares one 18x32 multiplier
// over its three products after the node read, an axial plane needs none.
// One query is in flight at a time; a finished result waits in the output
// register while the next item is taken. Reset is synchronous, resets
// control state and range registers; node memory holds no reset value.
// ----------------------------------------------------------------------------
module bsp_point_contents_walk #(
  parameter int unsigned NODE_COUNT = bpcw_pkg::NODE_COUNT_DEF,
  parameter int unsigned MAX_STEPS  = bpcw_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bpcw_req_if.sink                       req,
  bpcw_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpcw_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpcw_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpcw_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import bpcw_pkg::*;

  logic [IDX_W-1:0] first_valid_node;
  logic [IDX_W-1:0] last_valid_node;
  logic             req_ready;
  logic             rsp_valid;
  bpcw_cmd_t        cmd;
  bpcw_stat_t       stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LAST) ? PDATA_W'(last_valid_node)
                                         : PDATA_W'(first_valid_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid_node <= FIRST_RESET;
      last_valid_node  <= LAST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_LAST) begin
        last_valid_node <= pwdata[IDX_W-1:0];
      end else begin
        first_valid_node <= pwdata[IDX_W-1:0];
      end
    end
  end

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  bpcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bpcw_dp #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .first_valid_node (first_valid_node),
    .last_valid_node  (last_valid_node),
    .node_index       (req.node_index),
    .plane_type       (req.plane_type),
    .normal_x         (req.normal_x),
    .normal_y         (req.normal_y),
    .normal_z         (req.normal_z),
    .plane_distance   (req.plane_distance),
    .front_child      (req.front_child),
    .back_child       (req.back_child),
    .point_x          (req.point_x),
    .point_y          (req.point_y),
    .point_z          (req.point_z),
    .contents         (rsp.contents),
    .bad_node         (rsp.bad_node),
    .too_deep         (rsp.too_deep)
  );

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.bad_node && rsp.too_deep))
    else $error("Both error flags are set on one result.");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.bad_node || rsp.too_deep)) |-> (rsp.contents == '0))
    else $error("A flagged result carries nonzero contents.");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req_ready && (req.opcode == OP_QUERY)) |=> !req_ready)
    else $error("A new item was taken while a walk is in progress.");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req_ready && (req.opcode == OP_WRITE)) |=> req_ready)
    else $error("A node write left the walk sequencer busy.");
endmodule

// ===== tb/sv/bsp_point_contents_walk_test.sv =====
// ----------------------------------------------------------------------------
// bsp_point_contents_walk_test
// Loads BSP clip nodes, walks points through them and checks each leaf
// contents result, with its bad_node and too_deep flags, against a walk
// worked out in the bench from the same node table and range registers.
// ----------------------------------------------------------------------------
module bsp_point_contents_walk_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpcw_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD     = 300;

  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          index;
    logic [TYPE_W-1:0]         ptype;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic signed [COORD_W-1:0] pdist;
    logic signed [CHILD_W-1:0] front;
    logic signed [CHILD_W-1:0] back;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } walk_item_t;

  typedef struct {
    logic signed [CONT_W-1:0] contents;
    logic                     bad;
    logic                     deep;
  } walk_result_t;

  class contents_scoreboard;
    walk_item_t       node_tab [NODE_COUNT_DEF];
    logic [IDX_W-1:0] first_node;
    logic [IDX_W-1:0] last_node;
    walk_result_t     expected_q [$];
    int unsigned      errors;

    function new();
      first_node = FIRST_RESET;
      last_node  = LAST_RESET;
      errors     = 0;
    endfunction

    function void set_range(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
      first_node = first;
      last_node  = last;
    endfunction

    function logic [COORD_W-1:0] scaled_product(logic signed [NORM_W-1:0] n,
                                                logic signed [COORD_W-1:0] c);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] p;
      a = n;
      b = c;
      p = a * b;
      return p[47:16];
    endfunction

    function walk_result_t classify(walk_item_t it);
      walk_result_t     r;
      int               node;
      int unsigned      steps;
      logic             done;
      logic [COORD_W-1:0] d;
      logic [COORD_W-1:0] pt [3];
      walk_item_t       nd;
      r.contents = '0;
      r.bad      = 1'b0;
      r.deep     = 1'b0;
      pt[0] = it.px;
      pt[1] = it.py;
      pt[2] = it.pz;
      node  = int'(it.index);
      steps = 0;
      done  = 1'b0;
      while (node >= 0 && !done) begin
        if (node < int'(first_node) || node > int'(last_node) || node >= NODE_COUNT_DEF) begin
          r.bad = 1'b1;
          done  = 1'b1;
        end else if (steps >= MAX_STEPS_DEF) begin
          r.deep = 1'b1;
          done   = 1'b1;
        end else begin
          steps++;
          nd = node_tab[node];
          if (nd.ptype < AXIAL_TYPES) begin
            d = pt[nd.ptype] - nd.pdist;
          end else begin
            d = scaled_product(nd.nx, it.px) + scaled_product(nd.ny, it.py)
              + scaled_product(nd.nz, it.pz) - nd.pdist;
          end
          node = d[COORD_W-1] ? int'(nd.back) : int'(nd.front);
        end
      end
      if (!done) begin
        r.contents = CONT_W'((node < -16) ? -16 : node);
      end
      return r;
    endfunction

    function void note_item(walk_item_t it);
      if (it.op == OP_WRITE) begin
        node_tab[it.index] = it;
      end else begin
        expected_q.push_back(classify(it));
      end
    endfunction

    function void check_result(walk_result_t got);
      walk_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result contents=%0d bad_node=%0b too_deep=%0b",
                 $time, got.contents, got.bad, got.deep);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.contents !== want.contents || got.bad !== want.bad || got.deep !== want.deep)
      begin
        $display("%0t: mismatch expected contents=%0d bad_node=%0b too_deep=%0b",
                 $time, want.contents, want.bad, want.deep,
                 " actual contents=%0d bad_node=%0b too_deep=%0b",
                 got.contents, got.bad, got.deep);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bpcw_req_if req();
  bpcw_rsp_if rsp();

  bsp_point_contents_walk dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  contents_scoreboard sb;
  bit          written [NODE_COUNT_DEF];
  int          known [$];
  bit          idle_on;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned low_left;
    low_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else begin
        if (low_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
          low_left = $urandom_range(1, 7);
        end
        if (low_left > 0) begin
          low_left--;
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    walk_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.contents = rsp.contents;
      got.bad      = rsp.bad_node;
      got.deep     = rsp.too_deep;
      sb.check_result(got);
    end
  end

  function automatic logic signed [NORM_W-1:0] random_normal();
    return NORM_W'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [CHILD_W-1:0] random_leaf();
    if ($urandom_range(0, 19) == 0) begin
      return CHILD_W'(-int'($urandom_range(17, 4096)));
    end
    return CHILD_W'(-int'($urandom_range(1, 16)));
  endfunction

  function automatic logic signed [CHILD_W-1:0] random_child();
    if (known.size() == 0 || $urandom_range(0, 9) < 4) begin
      return random_leaf();
    end
    return CHILD_W'(known[$urandom_range(0, known.size() - 1)]);
  endfunction

  function automatic walk_item_t random_fields();
    walk_item_t it;
    it.op    = OP_WRITE;
    it.index = IDX_W'($urandom);
    it.ptype = TYPE_W'(($urandom_range(0, 19) == 0) ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5));
    it.nx    = random_normal();
    it.ny    = random_normal();
    it.nz    = random_normal();
    it.pdist = random_coord();
    it.front = random_leaf();
    it.back  = random_leaf();
    it.px    = random_coord();
    it.py    = random_coord();
    it.pz    = random_coord();
    return it;
  endfunction

  function automatic walk_item_t node_entry(logic [IDX_W-1:0] index, logic [TYPE_W-1:0] ptype,
                                            int nx, int ny, int nz, logic [COORD_W-1:0] pdist,
                                            int front, int back);
    walk_item_t it;
    it       = random_fields();
    it.op    = OP_WRITE;
    it.index = index;
    it.ptype = ptype;
    it.nx    = NORM_W'(nx);
    it.ny    = NORM_W'(ny);
    it.nz    = NORM_W'(nz);
    it.pdist = pdist;
    it.front = CHILD_W'(front);
    it.back  = CHILD_W'(back);
    return it;
  endfunction

  function automatic walk_item_t point_query(logic [IDX_W-1:0] index, logic [COORD_W-1:0] px,
                                             logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
    walk_item_t it;
    it       = random_fields();
    it.op    = OP_QUERY;
    it.index = index;
    it.px    = px;
    it.py    = py;
    it.pz    = pz;
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] pick_start();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom);
    if ($urandom_range(0, 5) == 0
        && (written[idx] || idx < sb.first_node || idx > sb.last_node)) begin
      return idx;
    end
    return IDX_W'(known[$urandom_range(0, known.size() - 1)]);
  endfunction

  task automatic send_item(walk_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.opcode         <= it.op;
    req.node_index     <= it.index;
    req.plane_type     <= it.ptype;
    req.normal_x       <= it.nx;
    req.normal_y       <= it.ny;
    req.normal_z       <= it.nz;
    req.plane_distance <= it.pdist;
    req.front_child    <= it.front;
    req.back_child     <= it.back;
    req.point_x        <= it.px;
    req.point_y        <= it.py;
    req.point_z        <= it.pz;
    req.valid          <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_node(walk_item_t it);
    send_item(it);
    if (!written[it.index]) begin
      written[it.index] = 1'b1;
      known.push_back(int'(it.index));
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_range_reg(logic sel, logic [IDX_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_range(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
    drain();
    write_range_reg(REG_FIRST, first);
    write_range_reg(REG_LAST, last);
    sb.set_range(first, last);
  endtask

  task automatic random_phase(int unsigned count);
    walk_item_t it;
    repeat (count) begin
      it = random_fields();
      if ($urandom_range(0, 99) < 45) begin
        it.op    = OP_WRITE;
        it.index = IDX_W'(($urandom_range(0, 9) < 6) ? known[$urandom_range(0, known.size() - 1)]
                                                     : $urandom);
        it.front = random_child();
        it.back  = random_child();
        write_node(it);
      end else begin
        it.op    = OP_QUERY;
        it.index = pick_start();
        send_item(it);
      end
    end
    drain();
  endtask

  // The tail is written first so every link points at a loaded node.
  task automatic chain_walk(int unsigned length);
    walk_item_t       it;
    logic [IDX_W-1:0] base;
    base = IDX_W'($urandom_range(0, NODE_COUNT_DEF - length - 1));
    for (int i = int'(length) - 1; i >= 0; i--) begin
      it       = random_fields();
      it.op    = OP_WRITE;
      it.index = IDX_W'(base + i);
      if (i != int'(length) - 1) begin
        it.front = CHILD_W'(base + i + 1);
        it.back  = CHILD_W'(base + i + 1);
      end
      write_node(it);
    end
    send_item(point_query(base, random_coord(), random_coord(), random_coord()));
    send_item(point_query(IDX_W'(base + 1), random_coord(), random_coord(), random_coord()));
    drain();
  endtask

  initial begin
    logic [IDX_W-1:0] lo;
    sb          = new();
    idle_on     = 1'b1;
    hold_cycles = 0;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req.valid          <= 1'b0;
    req.opcode         <= OP_WRITE;
    req.node_index     <= '0;
    req.plane_type     <= '0;
    req.normal_x       <= '0;
    req.normal_y       <= '0;
    req.normal_z       <= '0;
    req.plane_distance <= '0;
    req.front_child    <= '0;
    req.back_child     <= '0;
    req.point_x        <= '0;
    req.point_y        <= '0;
    req.point_z        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_range(FIRST_RESET, LAST_RESET);

    write_node(node_entry(0, 0, 0, 0, 0, 32'h0000_0000, -1, -2));
    write_node(node_entry(4095, 1, 0, 0, 0, 32'h7FFF_FFFF, -16, -3));
    write_node(node_entry(1, 2, 0, 0, 0, 32'h8000_0000, -4, -5));
    write_node(node_entry(2, 3, 65536, -65536, 1, 32'h0000_0000, 0, 4095));
    write_node(node_entry(3, 7, -65536, -65536, -65536, 32'h0000_0000, -17, -4096));
    write_node(node_entry(5, 6, 65536, 65536, 65536, 32'h0000_0000, 5, 5));
    write_node(node_entry(6, 4, 1234, -4321, 65536, 32'h0001_0000, 2, 1));
    send_item(point_query(0, 32'h0000_0000, $urandom, $urandom));
    send_item(point_query(0, 32'hFFFF_FFFF, $urandom, $urandom));
    send_item(point_query(0, 32'h7FFF_FFFF, $urandom, $urandom));
    send_item(point_query(0, 32'h8000_0000, $urandom, $urandom));
    send_item(point_query(4095, $urandom, 32'h8000_0000, $urandom));
    send_item(point_query(4095, $urandom, 32'hFFFF_FFFF, $urandom));
    send_item(point_query(1, $urandom, $urandom, 32'h0000_0000));
    send_item(point_query(1, $urandom, $urandom, 32'hFFFF_FFFF));
    send_item(point_query(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(point_query(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(point_query(3, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_item(point_query(3, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    send_item(point_query(5, $urandom, $urandom, $urandom));
    send_item(point_query(6, $urandom, $urandom, $urandom));
    set_range(2, 6);
    send_item(point_query(0, $urandom, $urandom, $urandom));
    send_item(point_query(6, $urandom, $urandom, $urandom));
    send_item(point_query(5, $urandom, $urandom, $urandom));
    set_range(FIRST_RESET, LAST_RESET);

    random_phase(100);
    chain_walk(MAX_STEPS_DEF);
    chain_walk(MAX_STEPS_DEF + 1);

    lo = IDX_W'($urandom_range(0, 2047));
    set_range(lo, IDX_W'($urandom_range(lo, 4095)));
    idle_on = 1'b0;
    random_phase(100);

    idle_on     = 1'b1;
    hold_cycles = LONG_HOLD;
    idle_on     = 1'b0;
    repeat (12) send_item(point_query(pick_start(), random_coord(), random_coord(),
                                      random_coord()));
    idle_on = 1'b1;
    drain();

    set_range(0, 0);
    random_phase(40);
    set_range(4095, 4095);
    random_phase(40);
    set_range(4095, 0);
    random_phase(30);

    set_range(FIRST_RESET, LAST_RESET);
    idle_on = 1'b0;
    random_phase(170);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bpcw_pkg.sv
rtl/core/bpcw_req_if.sv
rtl/core/bpcw_rsp_if.sv
rtl/core/bpcw_dp.sv
rtl/core/bpcw_ctrl.sv
rtl/core/bsp_point_contents_walk.sv
tb/sv/bsp_point_contents_walk_test.sv
